// File: hdl/grs_pkg.sv
// shared types and constants for the group reverse stream block
// no dependencies; imported by every module under hdl
package grs_pkg;

    localparam int MAX_GROUP  = 16;
    localparam int VALUE_W    = 32;
    localparam int GSIZE_W    = 5;
    localparam int CNT_W      = $clog2(MAX_GROUP + 1);
    localparam int GSIZE_RST  = 2;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CNT_W-1:0]          count_t;
    typedef logic [GSIZE_W-1:0]        gsize_t;

    // move applied alike to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHIFT_UP,
        OP_SHIFT_DOWN
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_ALIGN,
        ST_DRAIN_REV,
        ST_DRAIN_FWD
    } grs_state_t;

    // handshake and output flags from the controller
    typedef struct packed {
        logic in_ready;
        logic out_valid;
        logic run_last;
        logic seq_end;
        logic sel_top;
    } ctrl_status_t;

endpackage

// File: hdl/group_reverse_stream.sv
// group reverse stream: reverses values in groups over a chain of cells
// output: a full group drains from the next cycle on, newest first, one value
// per cycle while out_ready holds; a short final run shifts to the far end first
// and then drains oldest first; throughput: one input per cycle while filling,
// input stalls while a run aligns or drains, so groups never overlap
// reset clears the fill count, the sequencer and sets group size to 2
module group_reverse_stream (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  grs_pkg::gsize_t        cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  grs_pkg::value_t        element_value,
    input  logic                   sequence_end,
    output logic                   out_valid,
    input  logic                   out_ready,
    output grs_pkg::value_t        out_value,
    output logic                   run_last,
    output logic                   out_sequence_end
);
    import grs_pkg::*;

    cell_op_t     op;
    ctrl_status_t status;
    value_t       cell_value [MAX_GROUP];

    // sequencer
    grs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .sequence_end (sequence_end),
        .out_ready    (out_ready),
        .op           (op),
        .status       (status)
    );

    // chain of cells, cell 0 takes new values
    for (genvar i = 0; i < MAX_GROUP; i++)
    begin : g_cell
        value_t lower_in;
        value_t upper_in;
        if (i == 0)
        begin : g_first
            assign lower_in = element_value;
        end
        else
        begin : g_mid_lo
            assign lower_in = cell_value[i-1];
        end
        if (i == MAX_GROUP - 1)
        begin : g_last
            assign upper_in = '0;
        end
        else
        begin : g_mid_hi
            assign upper_in = cell_value[i+1];
        end
        grs_cell u_cell (
            .clk        (clk),
            .op         (op),
            .from_lower (lower_in),
            .from_upper (upper_in),
            .value      (cell_value[i])
        );
    end

    // output side
    assign in_ready         = status.in_ready;
    assign out_valid        = status.out_valid;
    assign run_last         = status.run_last;
    assign out_sequence_end = status.seq_end;
    assign out_value        = status.sel_top ? cell_value[MAX_GROUP-1] : cell_value[0];

    // input is never taken while a group drains
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted during drain");

    // end of sequence only on the last result of a transaction
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_sequence_end |-> run_last)
        else $error("sequence end without run last");

    // a final value always starts an output run
    a_end_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && sequence_end |=> !in_ready)
        else $error("final value did not flush");

endmodule

// File: hdl/grs_cell.sv
// one storage cell of the value chain
// depends on grs_pkg for the value type and the chain move codes
module grs_cell (
    input  logic              clk,
    input  grs_pkg::cell_op_t op,
    input  grs_pkg::value_t   from_lower,
    input  grs_pkg::value_t   from_upper,
    output grs_pkg::value_t   value
);
    import grs_pkg::*;

    value_t value_reg;
    value_t value_next;

    // pick hold, neighbor below or neighbor above
    always_comb
    begin
        case (op)
            OP_SHIFT_UP:   value_next = from_lower;
            OP_SHIFT_DOWN: value_next = from_upper;
            default:       value_next = value_reg;
        endcase
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: hdl/grs_ctrl.sv
// controller: group size register, fill count and drain sequencer
// depends on grs_pkg for counts, states, move codes and the status struct
module grs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  grs_pkg::gsize_t       cfg_wr_data,
    input  logic                  in_valid,
    input  logic                  sequence_end,
    input  logic                  out_ready,
    output grs_pkg::cell_op_t     op,
    output grs_pkg::ctrl_status_t status
);
    import grs_pkg::*;

    grs_state_t state_reg, state_next;
    gsize_t     gsize_reg;
    count_t     fill_reg, fill_next;
    count_t     remain_reg, remain_next;
    count_t     align_reg, align_next;
    logic       end_reg, end_next;
    count_t     eff_size;
    count_t     cnt_inc;

    // group size clamped to 1..MAX_GROUP
    always_comb
    begin
        if (gsize_reg == '0)
            eff_size = count_t'(1);
        else if (int'(gsize_reg) > MAX_GROUP)
            eff_size = count_t'(MAX_GROUP);
        else
            eff_size = count_t'(gsize_reg);
    end

    assign cnt_inc = fill_reg + count_t'(1);

    // next state and chain control
    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        remain_next      = remain_reg;
        align_next       = align_reg;
        end_next         = end_reg;
        op               = OP_HOLD;
        status           = '0;
        status.run_last  = (remain_reg == count_t'(1));
        status.seq_end   = (remain_reg == count_t'(1)) && end_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                status.in_ready = 1'b1;
                if (in_valid)
                begin
                    op       = OP_SHIFT_UP;
                    end_next = sequence_end;
                    if (cnt_inc >= eff_size)
                    begin
                        remain_next = cnt_inc;
                        state_next  = ST_DRAIN_REV;
                    end
                    else if (sequence_end)
                    begin
                        // short run: push oldest value up to the far end first
                        remain_next = cnt_inc;
                        align_next  = count_t'(MAX_GROUP) - cnt_inc;
                        state_next  = ST_ALIGN;
                    end
                    else
                    begin
                        fill_next = cnt_inc;
                    end
                end
            end
            ST_ALIGN:
            begin
                op         = OP_SHIFT_UP;
                align_next = align_reg - count_t'(1);
                if (align_reg == count_t'(1))
                    state_next = ST_DRAIN_FWD;
            end
            ST_DRAIN_REV, ST_DRAIN_FWD:
            begin
                status.out_valid = 1'b1;
                status.sel_top   = (state_reg == ST_DRAIN_FWD);
                if (out_ready)
                begin
                    op          = (state_reg == ST_DRAIN_FWD) ? OP_SHIFT_UP : OP_SHIFT_DOWN;
                    remain_next = remain_reg - count_t'(1);
                    if (remain_reg == count_t'(1))
                    begin
                        fill_next  = '0;
                        state_next = ST_FILL;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_FILL;
            gsize_reg  <= gsize_t'(GSIZE_RST);
            fill_reg   <= '0;
            remain_reg <= '0;
            align_reg  <= '0;
            end_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            remain_reg <= remain_next;
            align_reg  <= align_next;
            end_reg    <= end_next;
            if (cfg_wr_en)
                gsize_reg <= cfg_wr_data;
        end
    end

endmodule
